// ----- hdl/osm_pkg.sv -----
// shared types, sizes and codes of the order statistic multiset
package osm_pkg;

   localparam int Capacity   = 1024;
   localparam int ValueWidth = 32;
   localparam int CountWidth = $clog2(Capacity + 1);
   localparam int IndexWidth = $clog2(Capacity);

   typedef logic signed [ValueWidth-1:0] value_type;
   typedef logic [CountWidth-1:0]        count_type;
   typedef logic [IndexWidth-1:0]        index_type;

   typedef enum logic [2:0] {
      OP_INSERT      = 3'd0,
      OP_DELETE      = 3'd1,
      OP_RANK        = 3'd2,
      OP_SELECT      = 3'd3,
      OP_PREDECESSOR = 3'd4,
      OP_SUCCESSOR   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   // control from the sequencer to the head of the ring
   typedef struct packed {
      logic      start;
      logic      active;
      op_type    op;
      value_type operand;
      count_type count;
      index_type index;
   } scan_ctrl_type;

   // outcome of one full revolution
   typedef struct packed {
      value_type  answer;
      status_type status;
      logic       shrink;
   } scan_result_type;

endpackage

// ----- hdl/osm_cell.sv -----
// one storage cell of the value ring
module osm_cell (
   input  logic                clock,
   input  logic                shift,
   input  osm_pkg::value_type  d,
   output osm_pkg::value_type  q
);
   import osm_pkg::*;

   value_type value_ff;
   value_type value_in;

   assign value_in = shift ? d : value_ff;

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign q = value_ff;

endmodule

// ----- hdl/osm_chain.sv -----
// ring of storage cells, element order runs from the tail backwards
module osm_chain (
   input  logic                clock,
   input  logic                shift,
   input  osm_pkg::value_type  head,
   output osm_pkg::value_type  tail,
   output osm_pkg::value_type  upcoming
);
   import osm_pkg::*;

   value_type link [Capacity];

   genvar i;
   generate
      for (i = 0; i < Capacity; i++) begin : g_cell
         if (i == 0) begin : g_first
            osm_cell u_cell (
               .clock (clock),
               .shift (shift),
               .d     (head),
               .q     (link[i])
            );
         end else begin : g_rest
            osm_cell u_cell (
               .clock (clock),
               .shift (shift),
               .d     (link[i-1]),
               .q     (link[i])
            );
         end
      end
   endgenerate

   // the element after the one leaving, used to close the gap on delete
   assign tail     = link[Capacity-1];
   assign upcoming = link[Capacity-2];

endmodule

// ----- hdl/osm_scan.sv -----
// head of the ring: sees one element a cycle, rewrites the stream and gathers answers
module osm_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  osm_pkg::scan_ctrl_type    ctrl,
   input  osm_pkg::value_type        tail,
   input  osm_pkg::value_type        upcoming,
   output osm_pkg::value_type        head,
   output osm_pkg::scan_result_type  result
);
   import osm_pkg::*;

   logic      inserted_ff, inserted_in;
   logic      found_ff, found_in;
   logic      picked_ff, picked_in;
   value_type hold_ff, hold_in;
   value_type pick_ff, pick_in;
   count_type below_ff, below_in;

   logic                  live;
   logic                  lt;
   logic                  gt;
   logic                  eq;
   logic                  ins_hit;
   logic                  del_hit;
   logic [ValueWidth-1:0] position;

   assign live     = count_type'(ctrl.index) < ctrl.count;
   assign lt       = tail < ctrl.operand;
   assign gt       = tail > ctrl.operand;
   assign eq       = tail == ctrl.operand;
   assign position = ValueWidth'(ctrl.index) + ValueWidth'(1);
   assign ins_hit  = !inserted_ff && (!live || gt);
   assign del_hit  = !found_ff && live && eq;

   always_comb begin
      head        = tail;
      inserted_in = inserted_ff;
      found_in    = found_ff;
      picked_in   = picked_ff;
      hold_in     = hold_ff;
      pick_in     = pick_ff;
      below_in    = below_ff;
      if (ctrl.start) begin
         inserted_in = 1'b0;
         found_in    = 1'b0;
         picked_in   = 1'b0;
         below_in    = '0;
      end else if (ctrl.active) begin
         case (ctrl.op)
            OP_INSERT: begin
               // new value goes in, everything behind it slips one place
               if (inserted_ff) begin
                  head = hold_ff;
               end else if (ins_hit) begin
                  head = ctrl.operand;
               end
               if (inserted_ff || ins_hit) begin
                  hold_in = tail;
               end
               inserted_in = inserted_ff || ins_hit;
            end
            OP_DELETE: begin
               if (found_ff || del_hit) begin
                  head = upcoming;
               end
               found_in = found_ff || del_hit;
            end
            OP_RANK: begin
               if (live && lt) begin
                  below_in = below_ff + count_type'(1);
               end
            end
            OP_SELECT: begin
               if (live && position == $unsigned(ctrl.operand)) begin
                  pick_in   = tail;
                  picked_in = 1'b1;
               end
            end
            OP_PREDECESSOR: begin
               // last smaller value wins
               if (live && lt) begin
                  pick_in   = tail;
                  picked_in = 1'b1;
               end
            end
            OP_SUCCESSOR: begin
               // first larger value wins
               if (live && gt && !picked_ff) begin
                  pick_in   = tail;
                  picked_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      pick_ff  <= pick_in;
      below_ff <= below_in;
      if (reset) begin
         inserted_ff <= 1'b0;
         found_ff    <= 1'b0;
         picked_ff   <= 1'b0;
      end else begin
         inserted_ff <= inserted_in;
         found_ff    <= found_in;
         picked_ff   <= picked_in;
      end
   end

   always_comb begin
      result.answer = '0;
      result.status = STATUS_OK;
      result.shrink = 1'b0;
      case (ctrl.op)
         OP_DELETE: begin
            result.shrink = found_ff;
         end
         OP_RANK: begin
            result.answer = value_type'(below_ff) + value_type'(1);
         end
         OP_SELECT, OP_PREDECESSOR, OP_SUCCESSOR: begin
            if (picked_ff) begin
               result.answer = pick_ff;
            end else begin
               result.status = STATUS_MISSING;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hdl/order_statistic_multiset.sv -----
// top level of the order statistic multiset
//
// Requests arrive as beats on the req_ channel: the operation in req_tuser and
// the operand in req_tdata. Every request gives exactly one response beat on
// the rsp_ channel: the answer in rsp_tdata and the status in rsp_tuser.
// The values sit sorted in a ring of Capacity cells. A request that reads or
// changes the store turns the ring once, one cell a cycle, past a single
// compare unit at its head, which also opens or closes a gap in the stream
// for insert and delete. Such a request has its response registered in the
// ST_FINISH state after the last cell has passed the head, and no new
// request is taken until the state is back in ST_IDLE, so one request is
// in flight at a time and the rate is set by the length of the ring.
// An insert into a full store and an unknown operation answer on the next
// cycle without turning the ring.
// A new request is taken once the previous response has gone or is leaving;
// while rsp_tready is low the response holds and req_tready stays low.
// Reset empties the store at once (the count clears, no clearing pass) and
// drops any response that has not been taken.
module order_statistic_multiset (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] operand
   input  logic [7:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] answer
   output logic [7:0]  rsp_tuser    // [1:0] status
);
   import osm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   index_type  index_ff, index_in;
   op_type     op_ff, op_in;
   value_type  operand_ff, operand_in;
   count_type  count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   value_type  rsp_answer_ff, rsp_answer_in;
   status_type rsp_status_ff, rsp_status_in;

   op_type          req_op;
   value_type       req_operand;
   logic            accept;
   logic            full_insert;
   logic            immediate;
   scan_ctrl_type   ctrl;
   scan_result_type result;
   value_type       head;
   value_type       tail;
   value_type       upcoming;

   assign req_op      = op_type'(req_tuser[2:0]);
   assign req_operand = value_type'(req_tdata);
   assign req_tready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept      = req_tvalid && req_tready;
   assign full_insert = (req_op == OP_INSERT) && (count_ff == count_type'(Capacity));
   assign immediate   = full_insert || (req_op > OP_SUCCESSOR);

   assign ctrl.start   = accept && !immediate;
   assign ctrl.active  = state_ff == ST_SCAN;
   assign ctrl.op      = op_ff;
   assign ctrl.operand = operand_ff;
   assign ctrl.count   = count_ff;
   assign ctrl.index   = index_ff;

   osm_chain u_chain (
      .clock    (clock),
      .shift    (ctrl.active),
      .head     (head),
      .tail     (tail),
      .upcoming (upcoming)
   );

   osm_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .tail     (tail),
      .upcoming (upcoming),
      .head     (head),
      .result   (result)
   );

   always_comb begin
      state_in      = state_ff;
      index_in      = index_ff;
      op_in         = op_ff;
      operand_in    = operand_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_answer_in = rsp_answer_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               operand_in = req_operand;
               index_in   = '0;
               if (immediate) begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = '0;
                  rsp_status_in = full_insert ? STATUS_FULL : STATUS_OK;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            index_in = index_ff + index_type'(1);
            if (index_ff == index_type'(Capacity - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_answer_in = result.answer;
            rsp_status_in = result.status;
            if (op_ff == OP_INSERT) begin
               count_in = count_ff + count_type'(1);
            end else if (result.shrink) begin
               count_in = count_ff - count_type'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      index_ff      <= index_in;
      op_ff         <= op_in;
      operand_ff    <= operand_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_answer_ff;
   assign rsp_tuser  = {6'b0, rsp_status_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(Capacity))
      else $error("element count above capacity");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready)
      else $error("request taken while the ring is turning");

   a_scan_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && index_ff != index_type'(Capacity - 1)
      |=> state_ff == ST_SCAN && index_ff == $past(index_ff) + index_type'(1))
      else $error("ring revolution skipped or stopped a step");

   a_finish_responds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |=> rsp_tvalid && state_ff == ST_IDLE)
      else $error("finished revolution gave no response");

   a_count_changes_at_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_FINISH |=> count_ff == $past(count_ff))
      else $error("element count changed outside the end of a revolution");

endmodule

// ----- test/tb.sv -----
// testbench of the order statistic multiset: directed edge cases, random traffic, fill to full
`timescale 1ns / 1ps

module tb;
   import osm_pkg::*;

   localparam int          MinValue     = 32'sh8000_0000;
   localparam int          MaxValue     = 32'sh7FFF_FFFF;
   localparam logic [2:0]  OpUnusedLow  = 3'd6;
   localparam logic [2:0]  OpUnusedHigh = 3'd7;
   // one ring turn plus the longest stall and gap, taken several times over
   localparam int          IdleLimit    = 8 * (Capacity + 2 + 40 + 40);

   typedef struct {
      value_type  answer;
      status_type status;
   } osm_response_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] operand
   logic [7:0]  req_tuser;   // [2:0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] answer
   logic [7:0]  rsp_tuser;   // [1:0] status

   int               sorted_store[$];
   osm_response_type awaited_answers[$];
   int               failures      = 0;
   int               requests_sent = 0;
   int               full_refusals = 0;
   int               peak_size     = 0;
   bit               steady_flow   = 1'b0;

   order_statistic_multiset u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int count_below(int v);
      int n;
      n = 0;
      while (n < sorted_store.size() && sorted_store[n] < v) n++;
      return n;
   endfunction

   function automatic int count_not_above(int v);
      int n;
      n = 0;
      while (n < sorted_store.size() && sorted_store[n] <= v) n++;
      return n;
   endfunction

   // updates the multiset and returns the response the block should give
   function automatic osm_response_type multiset_apply(logic [2:0] op, logic [31:0] operand);
      osm_response_type rsp;
      int               v;
      int               pos;
      v = operand;
      rsp.answer = '0;
      rsp.status = STATUS_OK;
      case (op)
         OP_INSERT: begin
            if (sorted_store.size() >= Capacity) begin
               rsp.status = STATUS_FULL;
               full_refusals++;
            end else begin
               pos = count_not_above(v);
               if (pos == sorted_store.size()) sorted_store.push_back(v);
               else sorted_store.insert(pos, v);
               if (sorted_store.size() > peak_size) peak_size = sorted_store.size();
            end
         end
         OP_DELETE: begin
            pos = count_below(v);
            if (pos < sorted_store.size() && sorted_store[pos] == v) sorted_store.delete(pos);
         end
         OP_RANK: begin
            rsp.answer = count_below(v) + 1;
         end
         OP_SELECT: begin
            if (v >= 1 && v <= sorted_store.size()) rsp.answer = sorted_store[v-1];
            else rsp.status = STATUS_MISSING;
         end
         OP_PREDECESSOR: begin
            pos = count_below(v);
            if (pos > 0) rsp.answer = sorted_store[pos-1];
            else rsp.status = STATUS_MISSING;
         end
         OP_SUCCESSOR: begin
            pos = count_not_above(v);
            if (pos < sorted_store.size()) rsp.answer = sorted_store[pos];
            else rsp.status = STATUS_MISSING;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // mostly no gap, sometimes a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_value(bit prefer_stored);
      int r;
      r = $urandom_range(0, 99);
      if (sorted_store.size() > 0 && r < (prefer_stored ? 60 : 15))
         return sorted_store[$urandom_range(0, sorted_store.size() - 1)];
      r = $urandom_range(0, 99);
      if (r < 40) return int'($urandom_range(0, 16)) - 8;
      if (r < 50) begin
         case ($urandom_range(0, 5))
            0: return MinValue;
            1: return MinValue + 1;
            2: return MaxValue;
            3: return MaxValue - 1;
            4: return 0;
            default: return -1;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [31:0] pick_rank();
      int n;
      n = sorted_store.size();
      if (n > 0 && $urandom_range(0, 99) < 70) return $urandom_range(1, n);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return n + 1;
         2: return -1;
         3: return MaxValue;
         4: return MinValue;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(input logic [2:0] op, input logic [31:0] operand);
      int               gap;
      osm_response_type predicted;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = {5'b0, op};
      req_tdata  = operand;
      do @(posedge clock); while (!req_tready);
      predicted = multiset_apply(op, operand);
      awaited_answers.push_back(predicted);
      requests_sent++;
   endtask

   // hold the sender off until every outstanding response is back
   task automatic wait_until_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (awaited_answers.size() != 0) @(negedge clock);
   endtask

   task automatic send_random_request(input bit queries_only);
      int          r;
      logic [2:0]  op;
      logic [31:0] operand;
      r = queries_only ? $urandom_range(50, 99) : $urandom_range(0, 99);
      if (r < 30) begin
         op = OP_INSERT;
         operand = pick_value(1'b0);
      end else if (r < 50) begin
         op = OP_DELETE;
         operand = pick_value(1'b1);
      end else if (r < 62) begin
         op = OP_RANK;
         operand = pick_value(1'b1);
      end else if (r < 76) begin
         op = OP_SELECT;
         operand = pick_rank();
      end else if (r < 86) begin
         op = OP_PREDECESSOR;
         operand = pick_value(1'b1);
      end else if (r < 96) begin
         op = OP_SUCCESSOR;
         operand = pick_value(1'b1);
      end else begin
         op = $urandom_range(0, 1) ? OpUnusedHigh : OpUnusedLow;
         operand = $urandom();
      end
      send_request(op, operand);
   endtask

   task automatic test_empty_store();
      steady_flow = 1'b1;
      send_request(OP_RANK, 0);
      send_request(OP_SELECT, 1);
      send_request(OP_PREDECESSOR, 0);
      send_request(OP_SUCCESSOR, 0);
      send_request(OP_DELETE, 7);
      send_request(OpUnusedLow, 32'hFFFF_FFFF);
      send_request(OpUnusedHigh, 0);
      wait_until_drained();
   endtask

   task automatic test_boundaries();
      steady_flow = 1'b0;
      send_request(OP_INSERT, MinValue);
      send_request(OP_INSERT, MaxValue);
      send_request(OP_INSERT, 0);
      send_request(OP_INSERT, -1);
      send_request(OP_INSERT, 5);
      send_request(OP_INSERT, 5);
      send_request(OP_RANK, MinValue);
      send_request(OP_RANK, MaxValue);
      send_request(OP_PREDECESSOR, MinValue);
      send_request(OP_SUCCESSOR, MaxValue);
      send_request(OP_PREDECESSOR, MaxValue);
      send_request(OP_SUCCESSOR, MinValue);
      send_request(OP_SELECT, 0);
      send_request(OP_SELECT, 32'hFFFF_FFFF);
      send_request(OP_SELECT, 6);
      send_request(OP_SELECT, 7);
      // duplicates: one copy goes, the other stays
      send_request(OP_DELETE, 5);
      send_request(OP_SUCCESSOR, 0);
      wait_until_drained();
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         send_random_request(1'b0);
      end
      wait_until_drained();
   endtask

   task automatic test_full_store();
      int victim;
      steady_flow = 1'b0;
      while (sorted_store.size() < Capacity) begin
         if ($urandom_range(0, 19) == 0) send_random_request(1'b1);
         else send_request(OP_INSERT, pick_value(1'b0));
      end
      send_request(OP_INSERT, MaxValue);
      send_request(OP_INSERT, MinValue);
      send_request(OP_SELECT, Capacity);
      send_request(OP_SELECT, Capacity + 1);
      send_request(OP_RANK, MaxValue);
      send_request(OP_PREDECESSOR, MaxValue);
      wait_until_drained();
      // free one slot, take it again, then bounce off the full store
      victim = sorted_store[$urandom_range(0, Capacity - 1)];
      send_request(OP_DELETE, victim);
      send_request(OP_INSERT, pick_value(1'b0));
      send_request(OP_INSERT, pick_value(1'b0));
      for (int i = 0; i < 30; i++) send_random_request(1'b0);
      wait_until_drained();
   endtask

   // response side: random backpressure
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      osm_response_type predicted;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (awaited_answers.size() == 0) begin
               $error("unexpected response beat: answer %0d, status %0d",
                      $signed(rsp_tdata), rsp_tuser[1:0]);
               failures++;
            end else begin
               predicted = awaited_answers.pop_front();
               if (rsp_tdata !== predicted.answer) begin
                  $error("answer mismatch: expected %0d, got %0d",
                         predicted.answer, $signed(rsp_tdata));
                  failures++;
               end
               if (rsp_tuser[1:0] !== predicted.status) begin
                  $error("status mismatch: expected %0d, got %0d",
                         predicted.status, rsp_tuser[1:0]);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_store();
      test_boundaries();
      test_random_mix(200);
      test_full_store();

      wait_until_drained();
      // one more ring turn to catch any stray response beat
      repeat (Capacity + 8) @(posedge clock);

      $display("run covered %0d requests over an empty, partly filled and full store",
               requests_sent);
      $display("store peaked at %0d values; %0d inserts were refused as full",
               peak_size, full_refusals);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
